[sv/lrgd_pkg.sv]
// Shared types and constants for the logistic regression trainer.
// Holds controller states, command and status structs and saturation helpers.
// Depends on nothing.
package lrgd_pkg;

    localparam int                   AccW     = 48;
    localparam int                   WgtW     = 32;
    localparam int                   LrW      = 24;
    localparam int                   ZW       = 42;
    localparam int                   ProdW    = 58;
    localparam logic [LrW-1:0]       LR_RESET = 24'd33554;

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_MUL_A    = 15'h0002,
        S_MUL_B    = 15'h0004,
        S_ZSUM     = 15'h0008,
        S_INDEX    = 15'h0010,
        S_ROM      = 15'h0020,
        S_ERR      = 15'h0040,
        S_ACC_A    = 15'h0080,
        S_ACC_B    = 15'h0100,
        S_DIV_INIT = 15'h0200,
        S_DIV      = 15'h0400,
        S_MUL_LO   = 15'h0800,
        S_MUL_HI   = 15'h1000,
        S_APPLY    = 15'h2000,
        S_FINISH   = 15'h4000
    } state_t;

    typedef enum logic [2:0] {
        MS_WA,
        MS_WB,
        MS_EA,
        MS_EB,
        MS_LO,
        MS_HI
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     z_init;
        logic     z_add;
        logic     idx_en;
        logic     rom_en;
        logic     err_en;
        logic     acc_a;
        logic     acc_b;
        logic     div_start;
        logic     lo_en;
        logic     apply;
        logic     clear;
        logic     out_load;
        logic [1:0] wsel;
    } cmd_t;

    typedef struct packed {
        logic train;
        logic batch_end;
        logic div_busy;
        logic out_busy;
    } status_t;

    function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW:0] v);
        logic signed [AccW-1:0] r;
        if (v[AccW] != v[AccW-1])
        begin
            r = v[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        end
        else
        begin
            r = v[AccW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [WgtW-1:0] sat_wgt(input logic signed [73:0] v);
        logic signed [WgtW-1:0] r;
        if (v > 74'sd2147483647)
        begin
            r = {1'b0, {(WgtW-1){1'b1}}};
        end
        else if (v < -74'sd2147483648)
        begin
            r = {1'b1, {(WgtW-1){1'b0}}};
        end
        else
        begin
            r = v[WgtW-1:0];
        end
        return r;
    endfunction

endpackage

[sv/lrgd_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Divides an unsigned dividend by the batch count; uses lrgd_pkg widths.
module lrgd_div
    import lrgd_pkg::*;
#(
    parameter int VW = 13
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [AccW-1:0] dividend,
    input  logic [VW-1:0]   divisor,
    output logic            busy,
    output logic [AccW-1:0] quotient
);

    localparam int NW = $clog2(AccW + 1);

    logic [VW:0]     rem_reg, rem_next;
    logic [AccW-1:0] quo_reg, quo_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [VW:0]     shifted;
    logic [VW+1:0]   trial;

    assign shifted = {rem_reg[VW-1:0], quo_reg[AccW-1]};
    assign trial   = {1'b0, shifted} - {2'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[VW+1])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[AccW-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[VW:0];
                quo_next = {quo_reg[AccW-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == NW'(AccW - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[sv/lrgd_ctrl.sv]
// Sequencing state machine for the trainer.
// Issues datapath commands from lrgd_pkg types and reacts to status flags.
module lrgd_ctrl
    import lrgd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] wsel_reg, wsel_next;

    always_comb
    begin
        state_next = state_reg;
        wsel_next  = wsel_reg;
        cmd        = '0;
        cmd.wsel   = wsel_reg;
        ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_WA;
                state_next  = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_WB;
                cmd.z_init  = 1'b1;
                state_next  = S_ZSUM;
            end
            S_ZSUM:
            begin
                cmd.z_add  = 1'b1;
                state_next = S_INDEX;
            end
            S_INDEX:
            begin
                cmd.idx_en = 1'b1;
                state_next = S_ROM;
            end
            S_ROM:
            begin
                cmd.rom_en = 1'b1;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                if (status.train)
                begin
                    cmd.err_en  = 1'b1;
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MS_EA;
                    state_next  = S_ACC_A;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_ACC_A:
            begin
                cmd.acc_a   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_EB;
                state_next  = S_ACC_B;
            end
            S_ACC_B:
            begin
                cmd.acc_b = 1'b1;
                wsel_next = 2'd0;
                state_next = status.batch_end ? S_DIV_INIT : S_FINISH;
            end
            S_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_LO;
                state_next  = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.lo_en   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_HI;
                state_next  = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                if (wsel_reg == 2'd2)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    wsel_next  = wsel_reg + 2'd1;
                    state_next = S_DIV_INIT;
                end
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wsel_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            wsel_reg  <= wsel_next;
        end
    end

endmodule

[sv/lrgd_dp.sv]
// Datapath of the trainer: weights, accumulators, shared multiplier, sigmoid ROM.
// Driven by lrgd_ctrl commands; instantiates lrgd_div; uses lrgd_pkg.
module lrgd_dp
    import lrgd_pkg::*;
#(
    parameter int MAX_BATCH       = 4096,
    parameter int SIGMOID_ENTRIES = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic                   cfg_we,
    input  logic [LrW-1:0]         cfg_wdata,
    input  logic                   func,
    input  logic signed [15:0]     feature_a,
    input  logic signed [15:0]     feature_b,
    input  logic                   label,
    input  logic                   last_in_batch,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [15:0]            probability,
    output logic                   predicted_class,
    output logic signed [WgtW-1:0] weight_bias,
    output logic signed [WgtW-1:0] weight_a,
    output logic signed [WgtW-1:0] weight_b,
    output logic                   weights_updated
);

    localparam int CW = $clog2(MAX_BATCH + 1);
    localparam int IW = $clog2(SIGMOID_ENTRIES);

    typedef logic [15:0] rom_t [SIGMOID_ENTRIES];

    function automatic logic [127:0] cdiv(input logic [127:0] num, input logic [127:0] den);
        logic [127:0] q;
        logic [127:0] r;
        q = '0;
        r = '0;
        for (int b = 127; b >= 0; b--)
        begin
            r = {r[126:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic rom_t build_rom();
        rom_t               r;
        logic signed [63:0] z;
        logic [127:0]       t, k, f, term, pos, neg, e, den, p;
        for (int i = 0; i < SIGMOID_ENTRIES; i++)
        begin
            z    = $signed(64'(cdiv(128'(i) << 20, 128'(SIGMOID_ENTRIES)))) - 64'sd524288;
            t    = 128'(z < 0 ? -z : z);
            k    = t >> 16;
            f    = (t & 128'hFFFF) << 16;
            term = 128'd4294967296;
            pos  = 128'd4294967296;
            neg  = '0;
            for (int n = 1; n <= 13; n++)
            begin
                term = cdiv((term * f) >> 32, 128'(n));
                if (n % 2 == 1)
                begin
                    neg = neg + term;
                end
                else
                begin
                    pos = pos + term;
                end
            end
            e = pos - neg;
            for (int j = 0; j < 8; j++)
            begin
                if (128'(j) < k)
                begin
                    e = (e * 128'd1580030169) >> 32;
                end
            end
            den = 128'd4294967296 + e;
            if (z >= 0)
            begin
                p = cdiv((128'd1 << 48) + (den >> 1), den);
            end
            else
            begin
                p = cdiv((e << 16) + (den >> 1), den);
            end
            r[i] = (p > 128'd65535) ? 16'hFFFF : p[15:0];
        end
        return r;
    endfunction

    localparam rom_t SIG_ROM = build_rom();
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(524288);

    logic [LrW-1:0]         lr_reg;
    logic signed [WgtW-1:0] w_reg [3];
    logic signed [AccW-1:0] acc_reg [3];
    logic [CW-1:0]          cnt_reg;
    logic                   func_reg, label_reg, last_reg, upd_reg;
    logic signed [15:0]     a_reg, b_reg;
    logic signed [ProdW-1:0] prod_reg;
    logic [AccW-1:0]        lo_reg;
    logic signed [ZW-1:0]   z_reg;
    logic [IW-1:0]          idx_reg;
    logic [15:0]            p_reg;
    logic                   neg_reg;

    logic                   out_valid_reg;
    logic [15:0]            out_p_reg;
    logic signed [WgtW-1:0] out_w_reg [3];
    logic                   out_upd_reg;

    logic signed [32:0]     mul_a;
    logic signed [24:0]     mul_b;
    logic signed [17:0]     err;
    logic signed [ProdW-1:0] psh;
    logic [IW-1:0]          idx_next;
    logic [19:0]            zoff;
    logic [20+IW-1:0]       scaled;
    logic [CW-1:0]          cnt_plus;
    logic signed [AccW-1:0] acc_sel;
    logic [AccW-1:0]        div_dividend;
    logic [AccW-1:0]        quo;
    logic                   div_busy;
    logic [72:0]            mag;
    logic signed [72:0]     sprod, step;
    logic signed [73:0]     wdiff;

    assign err = $signed({2'b00, p_reg}) - (label_reg ? 18'sd65536 : 18'sd0);

    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_WA:
            begin
                mul_a = {w_reg[1][WgtW-1], w_reg[1]};
                mul_b = {{9{a_reg[15]}}, a_reg};
            end
            MS_WB:
            begin
                mul_a = {w_reg[2][WgtW-1], w_reg[2]};
                mul_b = {{9{b_reg[15]}}, b_reg};
            end
            MS_EA:
            begin
                mul_a = {{15{err[17]}}, err};
                mul_b = {{9{a_reg[15]}}, a_reg};
            end
            MS_EB:
            begin
                mul_a = {{15{err[17]}}, err};
                mul_b = {{9{b_reg[15]}}, b_reg};
            end
            MS_LO:
            begin
                mul_a = {9'b0, quo[23:0]};
                mul_b = {1'b0, lr_reg};
            end
            MS_HI:
            begin
                mul_a = {9'b0, quo[47:24]};
                mul_b = {1'b0, lr_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign psh    = prod_reg >>> 8;
    assign zoff   = 20'(z_reg + Z_HALF);
    assign scaled = (20 + IW)'(zoff) * (20 + IW)'(SIGMOID_ENTRIES);

    always_comb
    begin
        priority if (z_reg < -Z_HALF)
        begin
            idx_next = '0;
        end
        else if (z_reg >= Z_HALF)
        begin
            idx_next = IW'(SIGMOID_ENTRIES - 1);
        end
        else
        begin
            idx_next = scaled[20+IW-1:20];
        end
    end

    assign cnt_plus     = cnt_reg + 1'b1;
    assign acc_sel      = acc_reg[cmd.wsel];
    assign div_dividend = acc_sel[AccW-1] ? AccW'(-acc_sel) : AccW'(acc_sel);

    lrgd_div #(.VW(CW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign mag   = {1'b0, prod_reg[47:0], 24'b0} + {25'b0, lo_reg};
    assign sprod = neg_reg ? -$signed(mag) : $signed(mag);
    assign step  = (cmd.wsel == 2'd0) ? (sprod >>> 24) : (sprod >>> 32);
    assign wdiff = {{42{w_reg[cmd.wsel][WgtW-1]}}, w_reg[cmd.wsel]} - {step[72], step};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg        <= LR_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i]   <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                lr_reg <= cfg_wdata;
            end
            if (cmd.err_en)
            begin
                acc_reg[0] <= sat_acc({acc_reg[0][AccW-1], acc_reg[0]}
                                      + {{31{err[17]}}, err});
            end
            if (cmd.acc_a)
            begin
                acc_reg[1] <= sat_acc({acc_reg[1][AccW-1], acc_reg[1]} + prod_reg[AccW:0]);
            end
            if (cmd.acc_b)
            begin
                acc_reg[2] <= sat_acc({acc_reg[2][AccW-1], acc_reg[2]} + prod_reg[AccW:0]);
                cnt_reg    <= cnt_plus;
            end
            if (cmd.apply)
            begin
                w_reg[cmd.wsel] <= sat_wgt(wdiff);
            end
            if (cmd.clear)
            begin
                cnt_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    acc_reg[i] <= '0;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg  <= func;
            a_reg     <= feature_a;
            b_reg     <= feature_b;
            label_reg <= label;
            last_reg  <= last_in_batch;
            upd_reg   <= 1'b0;
        end
        if (cmd.acc_b)
        begin
            upd_reg <= status.batch_end;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= ProdW'(mul_a * mul_b);
        end
        if (cmd.z_init)
        begin
            z_reg <= $signed({{(ZW-WgtW){w_reg[0][WgtW-1]}}, w_reg[0]}) + psh[ZW-1:0];
        end
        if (cmd.z_add)
        begin
            z_reg <= z_reg + psh[ZW-1:0];
        end
        if (cmd.idx_en)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.rom_en)
        begin
            p_reg <= SIG_ROM[idx_reg];
        end
        if (cmd.div_start)
        begin
            neg_reg <= acc_sel[AccW-1];
        end
        if (cmd.lo_en)
        begin
            lo_reg <= prod_reg[AccW-1:0];
        end
        if (cmd.out_load)
        begin
            out_p_reg   <= p_reg;
            out_upd_reg <= upd_reg;
            for (int i = 0; i < 3; i++)
            begin
                out_w_reg[i] <= w_reg[i];
            end
        end
    end

    assign status.train     = !func_reg;
    assign status.batch_end = last_reg || (cnt_plus >= CW'(MAX_BATCH));
    assign status.div_busy  = div_busy;
    assign status.out_busy  = out_valid_reg && out_stall;

    assign out_valid       = out_valid_reg;
    assign probability     = out_p_reg;
    assign predicted_class = out_p_reg[15];
    assign weight_bias     = out_w_reg[0];
    assign weight_a        = out_w_reg[1];
    assign weight_b        = out_w_reg[2];
    assign weights_updated = out_upd_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_BATCH))
        else $error("batch count beyond its limit");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> cnt_reg != '0)
        else $error("division started with an empty batch");

    a_apply_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> !div_busy && $past(cmd.lo_en))
        else $error("weight step applied before quotient was ready");

endmodule

[sv/logistic_regression_gd_trainer_unit.sv]
// Top level of the two-feature logistic regression trainer.
// Joins lrgd_ctrl and lrgd_dp; uses lrgd_pkg.
//
// Input beats carry func, two Q8.8 features, the label and the batch-end flag;
// a beat is taken when in_valid is high and in_stall is low. Every input beat
// yields one output beat with the Q0.16 probability, the class and the three
// Q16.16 weights as they stand after the beat.
// A predict beat and a mid-batch train beat each run from acceptance to the
// result register in a sequence set by the one shared multiplier and the
// registered sigmoid ROM read. A beat that ends a batch adds three weight
// updates, each bound by the bit-serial divider of 48 steps with its start and
// finish, two multiplier passes and the write-back. A new beat is accepted once
// the previous one has reached the output register, so the block takes no new
// beat before it is through with the last. While out_stall is high the result
// is held and the block finishes the next beat only up to its output stage.
// learn_rate is written with cfg_we and cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this. Reset
// clears the weights, accumulators and count, empties the output register and
// restores the default step size.
module logistic_regression_gd_trainer_unit
    import lrgd_pkg::*;
#(
    parameter int MAX_BATCH       = 4096,
    parameter int SIGMOID_ENTRIES = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [LrW-1:0]         cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   func,
    input  logic signed [15:0]     feature_a,
    input  logic signed [15:0]     feature_b,
    input  logic                   label,
    input  logic                   last_in_batch,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [15:0]            probability,
    output logic                   predicted_class,
    output logic signed [WgtW-1:0] weight_bias,
    output logic signed [WgtW-1:0] weight_a,
    output logic signed [WgtW-1:0] weight_b,
    output logic                   weights_updated
);

    cmd_t    cmd;
    status_t status;
    logic    ready;

    lrgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .ready    (ready),
        .status   (status),
        .cmd      (cmd)
    );

    lrgd_dp #(
        .MAX_BATCH       (MAX_BATCH),
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .func            (func),
        .feature_a       (feature_a),
        .feature_b       (feature_b),
        .label           (label),
        .last_in_batch   (last_in_batch),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .probability     (probability),
        .predicted_class (predicted_class),
        .weight_bias     (weight_bias),
        .weight_a        (weight_a),
        .weight_b        (weight_b),
        .weights_updated (weights_updated)
    );

    assign in_stall = !ready;

endmodule
